// ----- rtl/asba_pkg.sv -----
// Package: shared constants and types of the skyline atlas block allocator.
package asba_pkg;

  localparam int PAGE_SIZE    = 1024;
  localparam int MAX_PAGES    = 64;
  localparam int MAX_STYLES   = 4;
  localparam int RESULT_LIMIT = 4;

  // Fixed field widths of the channels
  localparam int DIM_W  = 11;
  localparam int STY_W  = 3;
  localparam int SIDX_W = 2;
  localparam int POS_W  = 10;
  localparam int PAGE_W = 6;
  localparam int STAT_W = 2;

  localparam int COL_W     = $clog2(PAGE_SIZE);
  localparam int HGT_W     = $clog2(PAGE_SIZE + 1);
  localparam int PG_W      = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int STY_LIMIT = (MAX_STYLES < RESULT_LIMIT) ? MAX_STYLES : RESULT_LIMIT;
  localparam int SUM_W     = ((HGT_W > DIM_W) ? HGT_W : DIM_W) + 1;
  localparam int LAST_COL  = PAGE_SIZE - 2;

  typedef logic [STAT_W-1:0] status_t;

  localparam status_t STAT_PLACED  = 2'd0;
  localparam status_t STAT_FULL    = 2'd1;
  localparam status_t STAT_NOPAGE  = 2'd2;
  localparam status_t STAT_RESTART = 2'd3;

  localparam logic KIND_RESTART = 1'b1;

endpackage

// ----- rtl/asba_if.sv -----
// Interfaces: request, result and configuration channels of the allocator.
interface asba_in_if import asba_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             kind;
  logic [DIM_W-1:0] rect_width;
  logic [DIM_W-1:0] rect_height;
  logic [STY_W-1:0] style_count;

  modport source (output valid, kind, rect_width, rect_height, style_count, input ready);
  modport sink   (input valid, kind, rect_width, rect_height, style_count, output ready);
endinterface

interface asba_out_if import asba_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SIDX_W-1:0] style_index;
  logic [POS_W-1:0]  pos_x;
  logic [POS_W-1:0]  pos_y;
  logic [PAGE_W-1:0] page;
  status_t           status;
  logic              last;

  modport source (output valid, style_index, pos_x, pos_y, page, status, last, input ready);
  modport sink   (input valid, style_index, pos_x, pos_y, page, status, last, output ready);
endinterface

interface asba_cfg_if import asba_pkg::*; ();
  logic valid;
  logic ready;
  logic data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ----- rtl/atlas_skyline_block_allocator_core.sv -----
// Top level: skyline block allocator for square atlas pages.
//
// Each face request places up to four equal rectangles on the current page, one per light
// style, at the leftmost start column whose window has the lowest tallest column. The column
// heights live in a PAGE_SIZE-entry height memory with one read port, and every placement of
// nonzero width that fits the page takes two passes over it: a forward pass that builds
// block-wise prefix maxima into a second memory, then a backward pass that forms suffix maxima
// and picks the window, each reading columns 0 to PAGE_SIZE-2, followed by writes that raise
// the chosen columns. When a face does not fit and retries are enabled, the whole face is
// placed again on a fresh page. Finishing a page starts a clearing pass over the height
// memory; the same pass runs after reset and on a restart request, and no request is taken
// while it runs (configuration writes are always taken). Results follow once the whole face
// is placed, one per cycle as the sink takes them; the next request is taken after the last
// result.
module atlas_skyline_block_allocator_core import asba_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  asba_in_if.sink   in_ch,
  asba_out_if.source out_ch,
  asba_cfg_if.sink  cfg_ch
);

  localparam int SIX_W = (STY_LIMIT > 1) ? $clog2(STY_LIMIT) : 1;
  localparam int CNT_W = $clog2(STY_LIMIT + 1);
  localparam int ST_W  = 4;

  localparam logic [ST_W-1:0] S_CLR   = 4'd0;
  localparam logic [ST_W-1:0] S_IDLE  = 4'd1;
  localparam logic [ST_W-1:0] S_PLACE = 4'd2;
  localparam logic [ST_W-1:0] S_FWD   = 4'd3;
  localparam logic [ST_W-1:0] S_BWD   = 4'd4;
  localparam logic [ST_W-1:0] S_FIT   = 4'd5;
  localparam logic [ST_W-1:0] S_WRITE = 4'd6;
  localparam logic [ST_W-1:0] S_NEXT  = 4'd7;
  localparam logic [ST_W-1:0] S_OUT   = 4'd8;

  localparam logic [1:0] CC_BOOT    = 2'd0;
  localparam logic [1:0] CC_RESTART = 2'd1;
  localparam logic [1:0] CC_ADVANCE = 2'd2;

  localparam logic [COL_W-1:0] COL_LAST = COL_W'(LAST_COL);
  localparam logic [COL_W-1:0] COL_TOP  = COL_W'(PAGE_SIZE - 1);

  // Control state
  logic [ST_W-1:0]  st_r, st_nxt;
  logic [COL_W-1:0] ca_r, ca_nxt;
  logic             act_r, act_nxt;
  logic             pv_r;
  logic [1:0]       cc_r, cc_nxt;
  logic [PG_W-1:0]  page_r, page_nxt;
  logic             ovf_r, ovf_nxt;
  logic             retry_r, retry_nxt;
  logic             fresh_r, fresh_nxt;
  logic [SIX_W-1:0] k_r, k_nxt;
  logic [SIX_W-1:0] oi_r, oi_nxt;

  // Payload and datapath registers
  logic [COL_W-1:0] pc_r;
  logic [DIM_W-1:0] w_r, w_nxt;
  logic [DIM_W-1:0] h_r, h_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [HGT_W-1:0] best_r, best_nxt;
  logic [COL_W-1:0] bx_r, bx_nxt;
  logic             found_r, found_nxt;
  logic [HGT_W-1:0] prun_r, prun_nxt;
  logic [HGT_W-1:0] srun_r, srun_nxt;
  logic [COL_W-1:0] fo_r, fo_nxt;
  logic [COL_W-1:0] bo_r, bo_nxt;
  logic [COL_W-1:0] wl_r, wl_nxt;
  status_t          stat_r, stat_nxt;
  logic [CNT_W-1:0] nres_r, nres_nxt;
  logic             outz_r, outz_nxt;
  logic [POS_W-1:0] pend_x_r [STY_LIMIT];
  logic [POS_W-1:0] pend_x_nxt [STY_LIMIT];
  logic [POS_W-1:0] pend_y_r [STY_LIMIT];
  logic [POS_W-1:0] pend_y_nxt [STY_LIMIT];

  // Memory ports
  logic             h_we;
  logic [HGT_W-1:0] h_wdata;
  logic [HGT_W-1:0] h_rdata;
  logic             p_we;
  logic [HGT_W-1:0] p_wdata;
  logic [COL_W-1:0] p_raddr;
  logic [HGT_W-1:0] p_rdata;

  // Datapath helpers
  logic [COL_W-1:0] wc;
  logic             w_zero;
  logic             w_fits;
  logic             issue;
  logic [HGT_W-1:0] p_val;
  logic [HGT_W-1:0] s_val;
  logic [HGT_W-1:0] wmax;
  logic             win_ok;
  logic             take;
  logic [SUM_W-1:0] top_sum;
  logic             fits;
  logic [CNT_W-1:0] sat_cnt;
  logic             page_end;
  logic             out_last;

  assign wc       = COL_W'(w_r);
  assign w_zero   = (w_r == '0);
  assign w_fits   = (int'(w_r) < PAGE_SIZE);
  assign issue    = act_r && ((st_r == S_FWD) || (st_r == S_BWD));
  // Prefix max restarts at each block start, suffix max at each block end
  assign p_val    = (fo_r == '0) ? h_rdata : ((h_rdata > prun_r) ? h_rdata : prun_r);
  assign s_val    = ((pc_r == COL_LAST) || (bo_r == (wc - 1'b1))) ? h_rdata
                    : ((h_rdata > srun_r) ? h_rdata : srun_r);
  assign wmax     = (s_val > p_rdata) ? s_val : p_rdata;
  assign win_ok   = (int'(pc_r) + int'(wc)) < PAGE_SIZE;
  // Scan runs right to left, so ties go to the later (leftmost) window
  assign take     = win_ok && (int'(wmax) < PAGE_SIZE) && (wmax <= best_r);
  assign top_sum  = SUM_W'(best_r) + SUM_W'(h_r);
  assign fits     = found_r && (int'(top_sum) <= PAGE_SIZE);
  assign sat_cnt  = (int'(in_ch.style_count) > STY_LIMIT) ? CNT_W'(STY_LIMIT)
                    : CNT_W'(in_ch.style_count);
  assign page_end = (int'(page_r) + 1) >= MAX_PAGES;
  assign out_last = ((CNT_W'(oi_r) + 1'b1) == nres_r);

  assign h_we    = (st_r == S_CLR) || (st_r == S_WRITE);
  assign h_wdata = (st_r == S_CLR) ? ((ca_r == '0) ? HGT_W'(1) : '0) : HGT_W'(top_sum);
  assign p_we    = (st_r == S_FWD) && pv_r;
  assign p_wdata = p_val;
  assign p_raddr = ca_r + wc - 1'b1;

  asba_ram #(.WIDTH(HGT_W), .DEPTH(PAGE_SIZE)) u_height_ram (
    .clk   (clk),
    .we    (h_we),
    .waddr (ca_r),
    .wdata (h_wdata),
    .raddr (ca_r),
    .rdata (h_rdata)
  );

  asba_ram #(.WIDTH(HGT_W), .DEPTH(PAGE_SIZE)) u_prefix_ram (
    .clk   (clk),
    .we    (p_we),
    .waddr (pc_r),
    .wdata (p_wdata),
    .raddr (p_raddr),
    .rdata (p_rdata)
  );

  assign in_ch.ready  = (st_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid       = (st_r == S_OUT);
  assign out_ch.style_index = SIDX_W'(oi_r);
  assign out_ch.pos_x       = outz_r ? '0 : pend_x_r[oi_r];
  assign out_ch.pos_y       = outz_r ? '0 : pend_y_r[oi_r];
  assign out_ch.page        = PAGE_W'(page_r);
  assign out_ch.status      = stat_r;
  assign out_ch.last        = out_last;

  always_comb begin
    st_nxt     = st_r;
    ca_nxt     = ca_r;
    act_nxt    = act_r;
    cc_nxt     = cc_r;
    page_nxt   = page_r;
    ovf_nxt    = ovf_r;
    retry_nxt  = retry_r;
    fresh_nxt  = fresh_r;
    k_nxt      = k_r;
    oi_nxt     = oi_r;
    w_nxt      = w_r;
    h_nxt      = h_r;
    cnt_nxt    = cnt_r;
    best_nxt   = best_r;
    bx_nxt     = bx_r;
    found_nxt  = found_r;
    prun_nxt   = prun_r;
    srun_nxt   = srun_r;
    fo_nxt     = fo_r;
    bo_nxt     = bo_r;
    wl_nxt     = wl_r;
    stat_nxt   = stat_r;
    nres_nxt   = nres_r;
    outz_nxt   = outz_r;
    pend_x_nxt = pend_x_r;
    pend_y_nxt = pend_y_r;

    if (cfg_ch.valid) begin
      retry_nxt = cfg_ch.data;
    end

    unique case (st_r)
      S_CLR: begin
        ca_nxt = ca_r + 1'b1;
        if (ca_r == COL_TOP) begin
          ca_nxt = '0;
          case (cc_r)
            CC_RESTART: begin
              stat_nxt = STAT_RESTART;
              nres_nxt = CNT_W'(1);
              outz_nxt = 1'b1;
              oi_nxt   = '0;
              st_nxt   = S_OUT;
            end
            CC_ADVANCE: begin
              if (retry_r) begin
                fresh_nxt = 1'b1;
                k_nxt     = '0;
                st_nxt    = S_PLACE;
              end else begin
                stat_nxt = STAT_FULL;
                nres_nxt = CNT_W'(1);
                outz_nxt = 1'b1;
                oi_nxt   = '0;
                st_nxt   = S_OUT;
              end
            end
            default: begin
              st_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_IDLE: begin
        if (in_ch.valid) begin
          w_nxt = in_ch.rect_width;
          h_nxt = in_ch.rect_height;
          if (in_ch.kind == KIND_RESTART) begin
            page_nxt = '0;
            ovf_nxt  = 1'b0;
            cc_nxt   = CC_RESTART;
            ca_nxt   = '0;
            st_nxt   = S_CLR;
          end else if (ovf_r) begin
            stat_nxt = STAT_NOPAGE;
            nres_nxt = CNT_W'(1);
            outz_nxt = 1'b1;
            oi_nxt   = '0;
            st_nxt   = S_OUT;
          end else if (in_ch.style_count == '0) begin
            stat_nxt = STAT_PLACED;
            nres_nxt = CNT_W'(1);
            outz_nxt = 1'b1;
            oi_nxt   = '0;
            st_nxt   = S_OUT;
          end else begin
            cnt_nxt   = sat_cnt;
            k_nxt     = '0;
            fresh_nxt = 1'b0;
            st_nxt    = S_PLACE;
          end
        end
      end

      S_PLACE: begin
        best_nxt  = HGT_W'(PAGE_SIZE);
        found_nxt = 1'b0;
        if (w_zero) begin
          // empty window: last start column wins at row 0
          found_nxt = 1'b1;
          best_nxt  = '0;
          bx_nxt    = COL_TOP;
          st_nxt    = S_FIT;
        end else if (!w_fits) begin
          st_nxt = S_FIT;
        end else begin
          ca_nxt  = '0;
          act_nxt = 1'b1;
          fo_nxt  = '0;
          st_nxt  = S_FWD;
        end
      end

      S_FWD: begin
        if (act_r) begin
          ca_nxt = ca_r + 1'b1;
          if (ca_r == COL_LAST) begin
            act_nxt = 1'b0;
          end
        end
        if (pv_r) begin
          prun_nxt = p_val;
          fo_nxt   = (fo_r == (wc - 1'b1)) ? '0 : fo_r + 1'b1;
          if (pc_r == COL_LAST) begin
            // hand the block phase of the top column to the backward pass
            bo_nxt  = fo_r;
            ca_nxt  = COL_LAST;
            act_nxt = 1'b1;
            st_nxt  = S_BWD;
          end
        end
      end

      S_BWD: begin
        if (act_r) begin
          ca_nxt = ca_r - 1'b1;
          if (ca_r == '0) begin
            act_nxt = 1'b0;
          end
        end
        if (pv_r) begin
          srun_nxt = s_val;
          bo_nxt   = (bo_r == '0) ? (wc - 1'b1) : bo_r - 1'b1;
          if (take) begin
            best_nxt  = wmax;
            bx_nxt    = pc_r;
            found_nxt = 1'b1;
          end
          if (pc_r == '0) begin
            st_nxt = S_FIT;
          end
        end
      end

      S_FIT: begin
        if (fits) begin
          pend_x_nxt[k_r] = POS_W'(bx_r);
          pend_y_nxt[k_r] = POS_W'(best_r);
          if (w_zero) begin
            st_nxt = S_NEXT;
          end else begin
            ca_nxt = bx_r;
            wl_nxt = wc;
            st_nxt = S_WRITE;
          end
        end else if (fresh_r || page_end) begin
          // a fresh page cannot take the face either, or the last page is reached: no page will
          ovf_nxt  = 1'b1;
          if (fresh_r) begin
            page_nxt = PG_W'(MAX_PAGES - 1);
          end
          stat_nxt = STAT_NOPAGE;
          nres_nxt = CNT_W'(1);
          outz_nxt = 1'b1;
          oi_nxt   = '0;
          st_nxt   = S_OUT;
        end else begin
          page_nxt = page_r + 1'b1;
          cc_nxt   = CC_ADVANCE;
          ca_nxt   = '0;
          st_nxt   = S_CLR;
        end
      end

      S_WRITE: begin
        if (wl_r == COL_W'(1)) begin
          st_nxt = S_NEXT;
        end else begin
          ca_nxt = ca_r + 1'b1;
          wl_nxt = wl_r - 1'b1;
        end
      end

      S_NEXT: begin
        if ((CNT_W'(k_r) + 1'b1) == cnt_r) begin
          stat_nxt = STAT_PLACED;
          nres_nxt = cnt_r;
          outz_nxt = 1'b0;
          oi_nxt   = '0;
          st_nxt   = S_OUT;
        end else begin
          k_nxt  = k_r + 1'b1;
          st_nxt = S_PLACE;
        end
      end

      S_OUT: begin
        if (out_ch.ready) begin
          if (out_last) begin
            st_nxt = S_IDLE;
          end else begin
            oi_nxt = oi_r + 1'b1;
          end
        end
      end

      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_CLR;
      ca_r    <= '0;
      act_r   <= 1'b0;
      pv_r    <= 1'b0;
      cc_r    <= CC_BOOT;
      page_r  <= '0;
      ovf_r   <= 1'b0;
      retry_r <= 1'b1;
      fresh_r <= 1'b0;
      k_r     <= '0;
      oi_r    <= '0;
    end else begin
      st_r    <= st_nxt;
      ca_r    <= ca_nxt;
      act_r   <= act_nxt;
      pv_r    <= issue;
      cc_r    <= cc_nxt;
      page_r  <= page_nxt;
      ovf_r   <= ovf_nxt;
      retry_r <= retry_nxt;
      fresh_r <= fresh_nxt;
      k_r     <= k_nxt;
      oi_r    <= oi_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pc_r     <= ca_r;
    w_r      <= w_nxt;
    h_r      <= h_nxt;
    cnt_r    <= cnt_nxt;
    best_r   <= best_nxt;
    bx_r     <= bx_nxt;
    found_r  <= found_nxt;
    prun_r   <= prun_nxt;
    srun_r   <= srun_nxt;
    fo_r     <= fo_nxt;
    bo_r     <= bo_nxt;
    wl_r     <= wl_nxt;
    stat_r   <= stat_nxt;
    nres_r   <= nres_nxt;
    outz_r   <= outz_nxt;
    pend_x_r <= pend_x_nxt;
    pend_y_r <= pend_y_nxt;
  end

`ifndef SYNTH
  a_scan_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    ((st_r == S_FWD) || (st_r == S_BWD)) |-> !h_we)
    else $error("height memory written during a scan");

  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && (in_ch.kind == KIND_RESTART))
      |=> ((st_r == S_CLR) && (page_r == '0) && !ovf_r))
    else $error("restart transaction did not start a clearing pass on page 0");

  a_fit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ((st_r == S_FIT) && found_r) |-> (int'(best_r) < PAGE_SIZE))
    else $error("chosen window height out of page");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_WRITE) |-> ((int'(ca_r) + int'(wl_r)) < PAGE_SIZE))
    else $error("column raise runs past the scanned range");
`endif

endmodule

// ----- rtl/asba_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
module asba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
